// ===== rtl/mat_pkg.sv =====
// Shared types and constants for the multi-alarm timer manager.
// No dependencies; every other file in rtl/ imports this package.
package mat_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 23;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [APB_ADDR_W-3:0] REG_TICK_PERIOD = '0;
    localparam logic [DELAY_W-1:0]    TICK_PERIOD_RST = DELAY_W'(1);

    localparam logic CMD_PROGRAM = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef struct packed {
        logic               command;
        logic [ID_W-1:0]    message_id;
        logic               periodic;
        logic [DELAY_W-1:0] delay;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0] expired_message;
        logic            last_of_run;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROG,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic prog;
        logic walk;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
    } t_dp_stat;

endpackage

// ===== rtl/mat_ctrl.sv =====
// Sequencer for the alarm manager: accepts commands and steps the datapath.
// Depends on mat_pkg.
module mat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cmd_tick,
    input  mat_pkg::t_dp_stat i_stat,
    output mat_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import mat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd_tick == CMD_TICK) ? ST_WALK : ST_PROG;
                end
            end
            ST_PROG:  n_state = ST_IDLE;
            ST_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_PROG:  o_cmd.prog  = 1'b1;
            ST_WALK:  o_cmd.walk  = 1'b1;
            ST_FLUSH: o_cmd.flush = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    a_walk_ends_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_stat.walk_done) |=> (r_state == ST_FLUSH))
        else $error("walk did not end in flush");
    a_flush_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |=> (r_state == ST_IDLE))
        else $error("flush did not return to idle");
    a_prog_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROG) |=> !busy)
        else $error("program request took more than one cycle");

endmodule

// ===== rtl/mat_dp.sv =====
// Datapath for the alarm manager: slot table, slot walker and result register.
// Depends on mat_pkg; driven by mat_ctrl.
module mat_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mat_pkg::t_dp_cmd              i_cmd,
    input  mat_pkg::t_item                i_item,
    input  logic [mat_pkg::DELAY_W-1:0]   i_tick_period,
    output mat_pkg::t_dp_stat             o_stat,
    output logic                          o_result_valid,
    output mat_pkg::t_result              o_result
);
    import mat_pkg::*;

    t_item                 r_item;
    logic [SLOT_IDX_W-1:0] r_idx;
    logic [ID_W-1:0]       r_msg    [NUM_SLOTS];
    logic                  r_per    [NUM_SLOTS];
    logic [DELAY_W-1:0]    r_reload [NUM_SLOTS];
    logic [DELAY_W-1:0]    r_rem    [NUM_SLOTS];
    logic                  r_pend_valid;
    logic [ID_W-1:0]       r_pend_msg;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  match_found;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;

    logic [ID_W-1:0]       cur_msg;
    logic [DELAY_W-1:0]    cur_rem;
    logic                  cur_expire;

    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
    logic [ID_W-1:0]       wr_msg;
    logic                  wr_per;
    logic [DELAY_W-1:0]    wr_reload;
    logic [DELAY_W-1:0]    wr_rem;

    // Lowest slot holding the requested id, and lowest free slot.
    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!match_found && r_msg[s] == r_item.message_id) begin
                match_found = 1'b1;
                match_idx   = SLOT_IDX_W'(s);
            end
            if (!free_found && r_msg[s] == '0) begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(s);
            end
        end
    end

    assign cur_msg    = r_msg[r_idx];
    assign cur_rem    = r_rem[r_idx];
    assign cur_expire = (cur_msg != '0) && (cur_rem <= i_tick_period);

    assign o_stat.walk_done = (r_idx == SLOT_IDX_W'(NUM_SLOTS - 1));

    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = r_idx;
        wr_msg    = cur_msg;
        wr_per    = r_per[r_idx];
        wr_reload = r_reload[r_idx];
        wr_rem    = cur_rem;
        if (i_cmd.prog && r_item.message_id != '0) begin
            wr_msg    = r_item.message_id;
            wr_per    = r_item.periodic;
            wr_reload = r_item.delay;
            wr_rem    = r_item.delay;
            if (match_found) begin
                wr_en  = 1'b1;
                wr_idx = match_idx;
                if (r_item.delay == '0) begin
                    // cancel: free the slot
                    wr_msg    = '0;
                    wr_per    = 1'b0;
                    wr_reload = '0;
                    wr_rem    = '0;
                end
            end else if (r_item.delay != '0 && free_found) begin
                wr_en  = 1'b1;
                wr_idx = free_idx;
            end
        end else if (i_cmd.walk && cur_msg != '0) begin
            wr_en = 1'b1;
            if (cur_expire) begin
                if (r_per[r_idx]) begin
                    wr_rem = r_reload[r_idx];
                end else begin
                    wr_msg    = '0;
                    wr_per    = 1'b0;
                    wr_reload = '0;
                    wr_rem    = '0;
                end
            end else begin
                wr_rem = cur_rem - i_tick_period;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_msg[s] <= '0;
            end
        end else if (wr_en) begin
            r_msg[wr_idx] <= wr_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_per[wr_idx]    <= wr_per;
            r_reload[wr_idx] <= wr_reload;
            r_rem[wr_idx]    <= wr_rem;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.walk) begin
            r_idx <= r_idx + SLOT_IDX_W'(1);
        end
    end

    // Hold each expiry pending until the next one or the flush, so the last of a tick can be flagged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= r_pend_valid && ((i_cmd.walk && cur_expire) || i_cmd.flush);
            if (i_cmd.walk && cur_expire) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk && cur_expire) begin
            r_pend_msg <= cur_msg;
        end
        r_out.expired_message <= r_pend_msg;
        r_out.last_of_run     <= i_cmd.flush;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.expired_message != '0))
        else $error("result carries a free-slot id");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_of_run) |=> !o_result_valid)
        else $error("result transfer after last of run");
    a_prog_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prog |=> !o_result_valid)
        else $error("program request produced a result");

endmodule

// ===== rtl/multi_alarm_timer_manager_core.sv =====
// Top level of the multi-alarm timer manager: APB register and glue.
// Depends on mat_pkg, mat_ctrl and mat_dp.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-------------------------
//   command  | start / busy                   | i_item   (t_item)
//   result   | o_result_valid (strobe)        | o_result (t_result)
//   config   | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// A program request holds busy high through the PROG state after the accepting
// edge (table update), then returns to idle.
// A tick holds busy high through the WALK state, one slot per cycle on the
// single slot-table walk port, then the FLUSH state that flags the last result.
// Results appear one per cycle at most: each one the cycle after the next expiry
// of the tick, the last one the cycle after the flush, with busy already low.
// Synchronous active-low reset frees every slot and sets tick_period to 1.
// The receiver takes each result in the cycle it is shown and cannot stall.
module multi_alarm_timer_manager_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mat_pkg::t_item                    i_item,
    output logic                              o_result_valid,
    output mat_pkg::t_result                  o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mat_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mat_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mat_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mat_pkg::*;

    logic [DELAY_W-1:0] r_tick_period;
    logic               reg_hit;
    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TICK_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_tick_period <= pwdata[DELAY_W-1:0];
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(r_tick_period) : '0;

    mat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd_tick (i_item.command),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .busy       (busy)
    );

    mat_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_item         (i_item),
        .i_tick_period  (r_tick_period),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
